FILE: hw/rtl/tnri_pkg.sv
// ----------------------------------------------------------------------------
// tnri_pkg
// Shared types and constants of the top-N ranked insertion block.
// ----------------------------------------------------------------------------
`default_nettype none

package tnri_pkg;

   localparam int CHART_SLOTS = 10;
   localparam int SLOT_W      = (CHART_SLOTS > 1) ? $clog2(CHART_SLOTS) : 1;
   localparam int FILL_W      = $clog2(CHART_SLOTS + 1);

   localparam int INDEX_W  = 16;
   localparam int PLAYS_W  = 24;
   localparam int SERIAL_W = 32;
   localparam int KEY_W    = 16;
   localparam int RANK_W   = 4;
   localparam int MODE_W   = 2;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 80;

   typedef enum logic [MODE_W-1:0] {
      MODE_MOST_PLAYED = 2'd0,
      MODE_RECENT      = 2'd1,
      MODE_FEWEST      = 2'd2
   } rank_mode_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EMIT = 1'b1
   } state_type;

   typedef struct packed {
      logic insert;     // candidate transfer with an entry accepted this cycle
      logic load_out;   // load next chart place into the output register
      logic clear_fill; // chart fully emitted, empty the row
   } ctl_cmd_type;

   typedef struct packed {
      logic out_free;   // output register empty or being taken
      logic last_place; // next loaded result ends the chart
   } ctl_status_type;

endpackage : tnri_pkg

`default_nettype wire

FILE: hw/rtl/tnri_ctrl.sv
// ----------------------------------------------------------------------------
// tnri_ctrl
// Controller: takes candidates while idle, walks the chart out on end of pool.
// ----------------------------------------------------------------------------
`default_nettype none

module tnri_ctrl
   import tnri_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_tvalid,
   output logic                req_tready,
   input  wire logic           req_tlast,
   input  wire logic           req_has_entry,
   input  wire ctl_status_type status,
   output ctl_cmd_type         cmd
);

   state_type state_ff, state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      accept         = 1'b0;
      cmd.insert     = 1'b0;
      cmd.load_out   = 1'b0;
      cmd.clear_fill = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            accept     = req_tvalid;
            cmd.insert = accept & req_has_entry;
            if (accept && req_tlast) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (status.last_place) begin
                  cmd.clear_fill = 1'b1;
                  state_in       = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule : tnri_ctrl

`default_nettype wire

FILE: hw/rtl/tnri_dp.sv
// ----------------------------------------------------------------------------
// tnri_dp
// Datapath: sorted insertion row with per-slot compare, mode register,
// chart read-out counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tnri_dp
   import tnri_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_valid,
   input  wire logic [MODE_W-1:0]   csr_data,
   input  wire logic [INDEX_W-1:0]  cand_index,
   input  wire logic [PLAYS_W-1:0]  cand_plays,
   input  wire logic [SERIAL_W-1:0] cand_serial,
   input  wire logic [KEY_W-1:0]    cand_key,
   input  wire ctl_cmd_type         cmd,
   output ctl_status_type           status,
   input  wire logic                rsp_tready,
   output logic                     rsp_valid,
   output logic [RANK_W-1:0]        rsp_rank,
   output logic [INDEX_W-1:0]       rsp_index,
   output logic [PLAYS_W-1:0]       rsp_plays,
   output logic [SERIAL_W-1:0]      rsp_serial,
   output logic                     rsp_empty,
   output logic                     rsp_last
);

   rank_mode_type       mode_ff;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [SLOT_W-1:0]   emit_ff, emit_in;

   logic [INDEX_W-1:0]  slot_index_ff  [CHART_SLOTS];
   logic [PLAYS_W-1:0]  slot_plays_ff  [CHART_SLOTS];
   logic [SERIAL_W-1:0] slot_serial_ff [CHART_SLOTS];
   logic [KEY_W-1:0]    slot_key_ff    [CHART_SLOTS];
   logic [INDEX_W-1:0]  slot_index_in  [CHART_SLOTS];
   logic [PLAYS_W-1:0]  slot_plays_in  [CHART_SLOTS];
   logic [SERIAL_W-1:0] slot_serial_in [CHART_SLOTS];
   logic [KEY_W-1:0]    slot_key_in    [CHART_SLOTS];
   logic [CHART_SLOTS-1:0] slot_we;

   logic [CHART_SLOTS-1:0] hit;
   logic [CHART_SLOTS-1:0] prior_hit;
   logic                   qualify;
   logic                   room;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [RANK_W-1:0]   rsp_rank_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [PLAYS_W-1:0]  rsp_plays_ff;
   logic [SERIAL_W-1:0] rsp_serial_ff;
   logic                rsp_empty_ff;
   logic                rsp_last_ff;

   // eligibility and per-slot rank compare
   always_comb begin
      qualify = 1'b0;
      hit     = '0;
      unique case (mode_ff)
         MODE_MOST_PLAYED: qualify = (cand_plays != '0);
         MODE_RECENT:      qualify = (cand_plays != '0) && (cand_serial != '0);
         MODE_FEWEST:      qualify = 1'b1;
         default:          qualify = 1'b0;
      endcase
      for (int j = 0; j < CHART_SLOTS; j++) begin
         if (FILL_W'(j) < fill_ff) begin
            unique case (mode_ff)
               MODE_MOST_PLAYED: hit[j] = cand_plays > slot_plays_ff[j];
               MODE_RECENT:      hit[j] = cand_serial > slot_serial_ff[j];
               MODE_FEWEST: begin
                  if (cand_plays != slot_plays_ff[j]) begin
                     hit[j] = cand_plays < slot_plays_ff[j];
                  end else begin
                     hit[j] = cand_key < slot_key_ff[j];
                  end
               end
               default:          hit[j] = 1'b0;
            endcase
         end
      end
   end

   // insertion: first hit takes the candidate, later slots shift down; with no hit it goes to the first free slot
   always_comb begin
      prior_hit[0] = 1'b0;
      for (int j = 1; j < CHART_SLOTS; j++) begin
         prior_hit[j] = prior_hit[j-1] | hit[j-1];
      end
      room = (|hit) || (fill_ff < FILL_W'(CHART_SLOTS));
      for (int j = 0; j < CHART_SLOTS; j++) begin
         slot_we[j]        = 1'b0;
         slot_index_in[j]  = cand_index;
         slot_plays_in[j]  = cand_plays;
         slot_serial_in[j] = cand_serial;
         slot_key_in[j]    = cand_key;
         if (prior_hit[j]) begin
            slot_we[j] = cmd.insert & qualify;
            if (j > 0) begin
               slot_index_in[j]  = slot_index_ff[j-1];
               slot_plays_in[j]  = slot_plays_ff[j-1];
               slot_serial_in[j] = slot_serial_ff[j-1];
               slot_key_in[j]    = slot_key_ff[j-1];
            end
         end else if (hit[j] || (FILL_W'(j) == fill_ff)) begin
            slot_we[j] = cmd.insert & qualify;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < CHART_SLOTS; j++) begin
         if (slot_we[j]) begin
            slot_index_ff[j]  <= slot_index_in[j];
            slot_plays_ff[j]  <= slot_plays_in[j];
            slot_serial_ff[j] <= slot_serial_in[j];
            slot_key_ff[j]    <= slot_key_in[j];
         end
      end
   end

   // fill count, read-out counter, output register
   always_comb begin
      fill_in = fill_ff;
      if (cmd.clear_fill) begin
         fill_in = '0;
      end else if (cmd.insert && qualify && room && (fill_ff < FILL_W'(CHART_SLOTS))) begin
         fill_in = fill_ff + FILL_W'(1);
      end
      emit_in = emit_ff;
      if (cmd.clear_fill) begin
         emit_in = '0;
      end else if (cmd.load_out) begin
         emit_in = emit_ff + SLOT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      status.out_free   = ~rsp_valid_ff | rsp_tready;
      status.last_place = (fill_ff == '0) ||
                          ((FILL_W'(emit_ff) + FILL_W'(1)) == fill_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_MOST_PLAYED;
         fill_ff      <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= rank_mode_type'(csr_data);
         end
         fill_ff      <= fill_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_last_ff <= status.last_place;
         if (fill_ff == '0) begin
            rsp_empty_ff  <= 1'b1;
            rsp_rank_ff   <= '0;
            rsp_index_ff  <= '0;
            rsp_plays_ff  <= '0;
            rsp_serial_ff <= '0;
         end else begin
            rsp_empty_ff  <= 1'b0;
            rsp_rank_ff   <= RANK_W'(emit_ff);
            rsp_index_ff  <= slot_index_ff[emit_ff];
            rsp_plays_ff  <= slot_plays_ff[emit_ff];
            rsp_serial_ff <= slot_serial_ff[emit_ff];
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_rank   = rsp_rank_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_plays  = rsp_plays_ff;
   assign rsp_serial = rsp_serial_ff;
   assign rsp_empty  = rsp_empty_ff;
   assign rsp_last   = rsp_last_ff;

endmodule : tnri_dp

`default_nettype wire

FILE: hw/rtl/top_n_ranked_insertion.sv
// ----------------------------------------------------------------------------
// top_n_ranked_insertion
// Keeps the best CHART_SLOTS candidates of a stream in a sorted row and
// emits the chart, best first, on the transfer marked last.
//
//   channel | dir | tdata / data                         | tuser       | tlast
//   req     | in  | index, plays, serial, key (88 b)     | has_entry   | end_of_pool
//   rsp     | out | rank, index, plays, serial (80 b)    | chart_empty | last_of_chart
//   csr     | in  | rank_mode (2 b)                      | -           | -
//
// On a candidate transfer all slots compare in parallel and the row shifts
// in the same edge. On end of pool the chart is read out one place per cycle
// while the output register is free or being taken, from the row (fill count
// places, or one empty marker); req_tready is low during that read-out. The
// output register lets the next candidate in while the final result still
// waits. Reset is synchronous and leaves the chart empty with mode most played.
// ----------------------------------------------------------------------------
`default_nettype none

module top_n_ranked_insertion
   import tnri_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // entry_index, play_count, last_played, tiebreak_key
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // has_entry
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rank_position, ranked_index, ranked_plays, ranked_serial, zero pad
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // chart_empty
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [MODE_W-1:0]     csr_data
);

   ctl_cmd_type         cmd;
   ctl_status_type      status;
   logic [RANK_W-1:0]   rsp_rank;
   logic [INDEX_W-1:0]  rsp_index;
   logic [PLAYS_W-1:0]  rsp_plays;
   logic [SERIAL_W-1:0] rsp_serial;

   assign csr_ready = 1'b1;

   tnri_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tlast     (req_tlast),
      .req_has_entry (req_tuser),
      .status        (status),
      .cmd           (cmd)
   );

   tnri_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .cand_index  (req_tdata[15:0]),
      .cand_plays  (req_tdata[39:16]),
      .cand_serial (req_tdata[71:40]),
      .cand_key    (req_tdata[87:72]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_rank    (rsp_rank),
      .rsp_index   (rsp_index),
      .rsp_plays   (rsp_plays),
      .rsp_serial  (rsp_serial),
      .rsp_empty   (rsp_tuser),
      .rsp_last    (rsp_tlast)
   );

   assign rsp_tdata = {4'b0000, rsp_serial, rsp_plays, rsp_index, rsp_rank};

endmodule : top_n_ranked_insertion

`default_nettype wire
